// ----- hdl/mbp_pkg.sv -----
// package: shared types and constants of the msb-first bit packer
`timescale 1ns / 1ps
package mbp_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 7;
  localparam int BYTE_W  = 8;

  // item commands
  localparam logic [CMD_W-1:0] CMD_BITS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VARINT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // largest field length that cmd 0 appends
  localparam logic [COUNT_W-1:0] MAX_FIELD = 7'd64;
  // varint group size and byte length
  localparam int                 GROUP_W   = 7;
  localparam logic [COUNT_W-1:0] VBYTE_LEN = 7'd8;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture an accepted item
    logic step;       // move source bits into the accumulator
    logic group;      // load the next varint group
    logic emit_held;  // send the held byte, not last
    logic emit_byte;  // send the top accumulator byte
    logic hold_byte;  // park the final byte of a word
    logic finish;     // send the held byte as the last one
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;        // current step completes a word
    logic src_empty;   // no source bits left
    logic vmore;       // another varint group is to come
    logic held_valid;  // a byte is parked
    logic last_idx;    // byte index points at the final byte of the word
    logic out_free;    // output register can take a byte
  } dp_sts_t;

endpackage

// ----- hdl/mbp_item_if.sv -----
// interface: input item channel
`timescale 1ns / 1ps
interface mbp_item_if;
  logic                         valid;
  logic                         ready;
  logic [mbp_pkg::CMD_W-1:0]    cmd;
  logic [mbp_pkg::VALUE_W-1:0]  value;
  logic [mbp_pkg::COUNT_W-1:0]  bit_count;

  modport source (output valid, output cmd, output value, output bit_count, input ready);
  modport sink   (input valid, input cmd, input value, input bit_count, output ready);
endinterface

// ----- hdl/mbp_result_if.sv -----
// interface: output byte channel
`timescale 1ns / 1ps
interface mbp_result_if;
  logic                        valid;
  logic                        ready;
  logic [mbp_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ----- hdl/msb_first_bit_packer_with_varint.sv -----
// top level: msb-first bit packer with unsigned varint encoding
`timescale 1ns / 1ps
// Usage:
//   item channel (valid/ready) takes a command, a 64-bit value and a bit count:
//   cmd 0 appends the low bit_count bits (counts above 64 act as 64), cmd 1
//   appends the value as an unsigned LEB128 varint, cmd 2 zero-pads to the next
//   word boundary (a whole zero word when nothing is pending), cmd 3 is a no-op.
//   result channel (valid/ready) carries one byte per transfer, most significant
//   byte of each completed word first; last_byte marks an item's final byte.
//   Items that complete no word produce no transfer.
// Flow:
//   an item holds the input through take, append and close, plus a group load
//   and an append per varint group and the byte emission of each completed word;
//   a parked byte is sent ahead of each later word, and an append follows each
//   word that leaves source bits over; the final byte is registered at the close.
//   One shared append shifter and the byte-wide output register serve every
//   item; one item is in work at a time.
//   A finished byte waits in the output register while the next item is taken.
// Reset (synchronous, rst high) empties the pending word and the output
// register. When the receiver stalls, emission pauses with the current byte
// held stable and input stops being taken until the item has drained.
module msb_first_bit_packer_with_varint #(
  parameter int WORD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  mbp_item_if.sink     item,
  mbp_result_if.source result
);

  // word size rounded down to whole bytes and kept within 8..64
  localparam int W_RND = (WORD_BITS / 8) * 8;
  localparam int W_EFF = (W_RND < 8) ? 8 : ((W_RND > 64) ? 64 : W_RND);

  mbp_pkg::dp_cmd_t ctl;
  mbp_pkg::dp_sts_t sts;

  // controller
  mbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_cmd   (item.cmd),
    .item_ready (item.ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  // datapath
  mbp_dp #(
    .WORD_W (W_EFF)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .item_cmd       (item.cmd),
    .item_value     (item.value),
    .item_bit_count (item.bit_count),
    .out_ready      (result.ready),
    .out_valid      (result.valid),
    .out_byte       (result.out_byte),
    .out_last       (result.last_byte)
  );

endmodule

// ----- hdl/mbp_ctrl.sv -----
// controller: sequences append, varint groups and byte emission
`timescale 1ns / 1ps
module mbp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic [mbp_pkg::CMD_W-1:0]  item_cmd,
  output logic                       item_ready,
  input  mbp_pkg::dp_sts_t           sts,
  output mbp_pkg::dp_cmd_t           ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_EMIT   = 5'b00100,
    S_VGROUP = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && (item_cmd != mbp_pkg::CMD_NONE)) begin
          ctl.load   = 1'b1;
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ctl.step = 1'b1;
        priority if (sts.full) begin
          state_next = S_EMIT;
        end else if (sts.vmore) begin
          state_next = S_VGROUP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_VGROUP: begin
        ctl.group  = 1'b1;
        state_next = S_APPEND;
      end
      S_EMIT: begin
        // release the parked byte of the previous word first
        priority if (sts.held_valid) begin
          ctl.emit_held = sts.out_free;
        end else if (!sts.last_idx) begin
          ctl.emit_byte = sts.out_free;
        end else begin
          ctl.hold_byte = 1'b1;
          priority if (!sts.src_empty) begin
            state_next = S_APPEND;
          end else if (sts.vmore) begin
            state_next = S_VGROUP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.held_valid) begin
          if (sts.out_free) begin
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // a byte is only sent when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_held || ctl.emit_byte || ctl.finish) |-> sts.out_free)
    else $error("byte sent into a busy output register");

  // a new item is only taken with no byte parked from the previous one
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (item_ready && item_valid) |-> !sts.held_valid)
    else $error("item accepted with a parked byte");
`endif

endmodule

// ----- hdl/mbp_dp.sv -----
// datapath: bit accumulator, source shifter, varint splitter, output register
`timescale 1ns / 1ps
module mbp_dp #(
  parameter int WORD_W = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mbp_pkg::dp_cmd_t             ctl,
  output mbp_pkg::dp_sts_t             sts,
  input  logic [mbp_pkg::CMD_W-1:0]    item_cmd,
  input  logic [mbp_pkg::VALUE_W-1:0]  item_value,
  input  logic [mbp_pkg::COUNT_W-1:0]  item_bit_count,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [mbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last
);

  localparam int VW      = mbp_pkg::VALUE_W;
  localparam int CW      = mbp_pkg::COUNT_W;
  localparam int BW      = mbp_pkg::BYTE_W;
  localparam int N_BYTES = WORD_W / 8;
  localparam int BIDX_W  = (N_BYTES > 1) ? $clog2(N_BYTES) : 1;
  localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(N_BYTES - 1);
  localparam logic [CW-1:0]     WORD_LEN  = CW'(WORD_W);
  localparam logic [VW-1:0]     WORD_MASK = ~({VW{1'b1}} >> WORD_W);

  logic [VW-1:0]     acc;
  logic [CW-2:0]     count;
  logic [VW-1:0]     src;
  logic [CW-1:0]     src_n;
  logic [VW-1:0]     vrem;
  logic              vmore;
  logic [BW-1:0]     held;
  logic              held_valid;
  logic [BIDX_W-1:0] bidx;

  logic [CW:0]       fill_sum;
  logic              full;
  logic [CW-1:0]     room;
  logic [CW-1:0]     take;
  logic [CW-1:0]     field_n;
  logic              grp_more;
  logic              out_load;

  // append step arithmetic
  always_comb begin
    fill_sum = {2'b00, count} + {1'b0, src_n};
    full     = fill_sum >= {1'b0, WORD_LEN};
    room     = WORD_LEN - {1'b0, count};
    take     = full ? room : src_n;
    field_n  = (item_bit_count > mbp_pkg::MAX_FIELD) ? mbp_pkg::MAX_FIELD : item_bit_count;
    grp_more = |vrem[VW-1:mbp_pkg::GROUP_W];
    out_load = ctl.emit_held || ctl.emit_byte || ctl.finish;
  end

  // accumulator and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (ctl.step) begin
      acc   <= (acc | (src >> count)) & WORD_MASK;
      count <= full ? '0 : fill_sum[CW-2:0];
    end else if (ctl.emit_byte || ctl.hold_byte) begin
      acc   <= acc << BW;
    end
  end

  // source bits, left-aligned, and remaining length
  always_ff @(posedge clk) begin
    if (rst) begin
      src_n <= '0;
      vmore <= 1'b0;
    end else if (ctl.load) begin
      unique case (item_cmd)
        mbp_pkg::CMD_BITS: begin
          src_n <= field_n;
          vmore <= 1'b0;
        end
        mbp_pkg::CMD_VARINT: begin
          src_n <= '0;
          vmore <= 1'b1;
        end
        mbp_pkg::CMD_FLUSH: begin
          src_n <= room;
          vmore <= 1'b0;
        end
        default: begin
          src_n <= '0;
          vmore <= 1'b0;
        end
      endcase
    end else if (ctl.group) begin
      src_n <= mbp_pkg::VBYTE_LEN;
      vmore <= grp_more;
    end else if (ctl.step) begin
      src_n <= src_n - take;
    end
  end

  // source and varint payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      src  <= (item_cmd == mbp_pkg::CMD_BITS) ? (item_value << (mbp_pkg::MAX_FIELD - field_n))
                                              : '0;
      vrem <= item_value;
    end else if (ctl.group) begin
      src  <= {grp_more, vrem[mbp_pkg::GROUP_W-1:0], {(VW-BW){1'b0}}};
      vrem <= vrem >> mbp_pkg::GROUP_W;
    end else if (ctl.step) begin
      src  <= src << take;
    end
  end

  // byte index within the word and parked final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bidx       <= '0;
      held_valid <= 1'b0;
    end else begin
      if (ctl.emit_byte) begin
        bidx <= bidx + 1'b1;
      end else if (ctl.hold_byte) begin
        bidx <= '0;
      end
      if (ctl.hold_byte) begin
        held_valid <= 1'b1;
      end else if (ctl.emit_held || ctl.finish) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hold_byte) begin
      held <= acc[VW-1:VW-BW];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= ctl.emit_byte ? acc[VW-1:VW-BW] : held;
      out_last <= ctl.finish;
    end
  end

  // status to the controller
  always_comb begin
    sts.full       = full;
    sts.src_empty  = (src_n == '0);
    sts.vmore      = vmore;
    sts.held_valid = held_valid;
    sts.last_idx   = (bidx == BIDX_LAST);
    sts.out_free   = !out_valid || out_ready;
  end

`ifndef SYNTH
  // a completed word clears the fill count
  a_full_clears: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && full) |=> (count == '0))
    else $error("fill count not cleared after a full word");

  // all bytes of a word shifted out once the final one is parked
  a_word_drained: assert property (@(posedge clk) disable iff (rst)
    ctl.hold_byte |=> (acc == '0) && held_valid)
    else $error("accumulator not empty after word drain");

  // the item's final byte goes out from the parked byte
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> out_valid && out_last && !held_valid)
    else $error("last byte not presented on finish");

  // fill count stays below the word size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} < WORD_LEN)
    else $error("fill count reached the word size");
`endif

endmodule

// ----- dv/msb_first_bit_packer_with_varint_tb.sv -----
// testbench: msb-first bit packer with varint, byte-level scoreboard and random traffic
`timescale 1ns / 1ps

// predicts the packed byte stream and checks each output transfer against it
class packer_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } exp_byte_t;

  logic [63:0]  acc_bits;
  int unsigned  acc_count;
  int unsigned  word_len;
  exp_byte_t    exp_bytes[$];
  int unsigned  n_fail;
  int unsigned  n_printed;

  function new(int unsigned word_bits);
    word_len = word_bits & ~32'd7;
    if (word_len < 8) word_len = 8;
    if (word_len > 64) word_len = 64;
    acc_bits = '0;
    acc_count = 0;
    n_fail = 0;
    n_printed = 0;
  endfunction

  function int unsigned outstanding();
    return exp_bytes.size();
  endfunction

  task report_mismatch(string what);
    n_fail++;
    if (n_printed < 40) begin
      n_printed++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  // one bit into the accumulator, word out once full
  function void shift_in(logic b);
    exp_byte_t e;
    acc_bits[63 - acc_count] = b;
    acc_count++;
    if (acc_count >= word_len) begin
      for (int k = 0; k < word_len / 8; k++) begin
        e.data = acc_bits[63 - 8 * k -: 8];
        e.last = 1'b0;
        exp_bytes.push_back(e);
      end
      acc_bits = '0;
      acc_count = 0;
    end
  endfunction

  // low n bits of v, msb first
  function void append_field(logic [63:0] v, int unsigned n);
    if (n > mbp_pkg::MAX_FIELD) n = mbp_pkg::MAX_FIELD;
    for (int i = n; i > 0; i--) shift_in(v[i - 1]);
  endfunction

  // accepted item: work out the bytes it causes
  function void note_item(logic [1:0] cmd, logic [63:0] value, logic [6:0] count);
    int unsigned size_before;
    logic [63:0] v;
    size_before = exp_bytes.size();
    case (cmd)
      mbp_pkg::CMD_BITS: begin
        append_field(value, count);
      end
      mbp_pkg::CMD_VARINT: begin
        // low group first, continuation bit on all but the final byte
        v = value;
        while (v > 64'd127) begin
          append_field({56'd0, 1'b1, v[mbp_pkg::GROUP_W-1:0]}, mbp_pkg::VBYTE_LEN);
          v = v >> mbp_pkg::GROUP_W;
        end
        append_field(v, mbp_pkg::VBYTE_LEN);
      end
      mbp_pkg::CMD_FLUSH: begin
        append_field('0, word_len - acc_count);
      end
      default: begin
      end
    endcase
    if (exp_bytes.size() > size_before) exp_bytes[exp_bytes.size() - 1].last = 1'b1;
  endfunction

  // output transfer against the oldest expected byte
  task check_byte(logic [7:0] data, logic last);
    exp_byte_t e;
    if (exp_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte 0x%02h last %0b", data, last));
    end else begin
      e = exp_bytes.pop_front();
      if (data !== e.data)
        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h", data, e.data));
      if (last !== e.last)
        report_mismatch($sformatf("last_byte %0b, expected %0b (byte 0x%02h)",
                                  last, e.last, e.data));
    end
  endtask
endclass

module msb_first_bit_packer_with_varint_tb;

  localparam int WORD_BITS    = 64;
  localparam int SETTLE_TICKS = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst;

  mbp_item_if   item_ch ();
  mbp_result_if byte_ch ();

  msb_first_bit_packer_with_varint #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch.sink),
    .result(byte_ch.source)
  );

  packer_scoreboard sb = new(WORD_BITS);

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("msb_first_bit_packer_with_varint_tb failed");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      byte_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watch both channels: check output transfers, predict from input transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) sb.check_byte(byte_ch.out_byte, byte_ch.last_byte);
      if (item_ch.valid && item_ch.ready)
        sb.note_item(item_ch.cmd, item_ch.value, item_ch.bit_count);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one item, with random idle cycles ahead of it
  task automatic send_item(logic [1:0] cmd, logic [63:0] value, logic [6:0] count);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= cmd;
    item_ch.value     <= value;
    item_ch.bit_count <= count;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // stop sending until every expected byte has come and the block settled
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // random traffic; ignored items are not counted
  task automatic run_random_phase(int unsigned n_items);
    int unsigned done_n;
    int unsigned pick;
    bit          paused;
    logic [1:0]  c;
    logic [63:0] v;
    logic [6:0]  n;
    done_n = 0;
    paused = 1'b0;
    while (done_n < n_items) begin
      pick = $urandom_range(99);
      v = rand64();
      n = 7'($urandom_range(127));
      if (pick < 40) begin
        c = mbp_pkg::CMD_BITS;
        if ($urandom_range(9) == 0) n = 7'($urandom_range(127, 65));
        else n = 7'($urandom_range(64, 1));
      end else if (pick < 78) begin
        // spread the group count of the varint
        c = mbp_pkg::CMD_VARINT;
        v = v >> $urandom_range(63);
      end else if (pick < 94) begin
        c = mbp_pkg::CMD_FLUSH;
      end else if (pick < 97) begin
        c = mbp_pkg::CMD_BITS;
        n = '0;
      end else begin
        c = mbp_pkg::CMD_NONE;
      end
      send_item(c, v, n);
      if (!(c == mbp_pkg::CMD_NONE || (c == mbp_pkg::CMD_BITS && n == '0))) done_n++;
      // hold off once mid-phase until the output has caught up
      if (!paused && done_n >= n_items / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.cmd       <= mbp_pkg::CMD_BITS;
    item_ch.value     <= '0;
    item_ch.bit_count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every command, corner cases
    send_item(mbp_pkg::CMD_FLUSH, rand64(), '0);           // flush with nothing pending
    send_item(mbp_pkg::CMD_BITS, '1, mbp_pkg::MAX_FIELD);  // full word of ones
    send_item(mbp_pkg::CMD_BITS, rand64(), '0);            // zero count, no output
    send_item(mbp_pkg::CMD_BITS, rand64(), 7'd127);        // count saturates to 64
    send_item(mbp_pkg::CMD_BITS, 64'd1, 7'd1);
    send_item(mbp_pkg::CMD_NONE, rand64(), 7'd127);        // unused command
    send_item(mbp_pkg::CMD_VARINT, 64'd0, '0);
    send_item(mbp_pkg::CMD_VARINT, 64'd127, '0);
    send_item(mbp_pkg::CMD_VARINT, 64'd128, '0);
    send_item(mbp_pkg::CMD_VARINT, '1, 7'd127);            // ten-byte varint crosses a word
    send_item(mbp_pkg::CMD_VARINT, 64'h8000_0000_0000_0000, '0);
    send_item(mbp_pkg::CMD_FLUSH, '1, 7'd127);
    send_item(mbp_pkg::CMD_BITS, '1, 7'd63);
    send_item(mbp_pkg::CMD_BITS, '1, 7'd1);                // completes the word exactly
    send_item(mbp_pkg::CMD_BITS, 64'h0123_4567_89ab_cdef, 7'd65);
    send_item(mbp_pkg::CMD_BITS, 64'h5, 7'd3);
    send_item(mbp_pkg::CMD_BITS, '0, mbp_pkg::MAX_FIELD);  // spans a word boundary
    send_item(mbp_pkg::CMD_FLUSH, '0, '0);                 // partial flush
    send_item(mbp_pkg::CMD_BITS, 64'h7f, 7'd7);
    send_item(mbp_pkg::CMD_VARINT, '1, '0);
    send_item(mbp_pkg::CMD_FLUSH, '0, '0);
    wait_drained();

    // random phases with different idling
    idle_pct = 0;  stall_pct = 0;  run_random_phase(45);
    idle_pct = 56; stall_pct = 0;  run_random_phase(40);
    idle_pct = 0;  stall_pct = 56; run_random_phase(40);
    idle_pct = 31; stall_pct = 31; run_random_phase(45);

    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected bytes never came", sb.outstanding()));
    if (sb.n_fail == 0) begin
      $display("msb_first_bit_packer_with_varint_tb passed");
    end else begin
      $display("msb_first_bit_packer_with_varint_tb failed");
    end
    $finish;
  end
endmodule
